// File: rtl/core/mntl_pkg.sv
// shared types, constants and lookup tables for the note to led color block
`timescale 1ns / 1ps
`default_nettype none

package mntl_pkg;

  // strip and message constants
  localparam int STRIP_LENGTH = 120;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [6:0] LOWEST_NOTE_RESET = 7'd36;

  localparam int CHAN_FULL        = 255;
  localparam int VEL_MAX          = 127;
  localparam int STEPS_PER_SECTOR = 10;
  localparam int SECTORS          = 6;
  localparam int HUE_SPAN         = STEPS_PER_SECTOR * SECTORS;
  // offset index so that note - lowest_note stays non-negative
  localparam int HUE_OFFSET       = 128;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // hue wheel sectors
  localparam logic [2:0] SECTOR_RED_YELLOW   = 3'd0;
  localparam logic [2:0] SECTOR_YELLOW_GREEN = 3'd1;
  localparam logic [2:0] SECTOR_GREEN_CYAN   = 3'd2;
  localparam logic [2:0] SECTOR_CYAN_BLUE    = 3'd3;
  localparam logic [2:0] SECTOR_BLUE_MAGENTA = 3'd4;

  // classified note event carried through the queue
  typedef struct packed {
    logic [6:0] led_index;
    logic [2:0] sector;
    logic [3:0] step;
    logic [7:0] bright;
  } note_item_t;

  typedef logic [255:0][6:0] hue_lut_t;
  typedef logic [127:0][6:0] idx_lut_t;
  typedef logic [127:0][7:0] bright_lut_t;
  typedef logic [15:0][7:0]  ramp_lut_t;

  // {sector, step} for index (note - lowest_note + HUE_OFFSET)
  function automatic hue_lut_t build_hue_lut();
    hue_lut_t lut;
    int v;
    for (int i = 0; i < 256; i++) begin
      v = (i - HUE_OFFSET + 3 * HUE_SPAN) % HUE_SPAN;
      lut[i] = {3'(v / STEPS_PER_SECTOR), 4'(v % STEPS_PER_SECTOR)};
    end
    return lut;
  endfunction

  function automatic idx_lut_t build_idx_lut();
    idx_lut_t lut;
    for (int i = 0; i < 128; i++) begin
      lut[i] = 7'(i % STRIP_LENGTH);
    end
    return lut;
  endfunction

  function automatic bright_lut_t build_bright_lut();
    bright_lut_t lut;
    for (int i = 0; i < 128; i++) begin
      lut[i] = 8'((i * CHAN_FULL) / VEL_MAX);
    end
    return lut;
  endfunction

  function automatic ramp_lut_t build_ramp_lut(input bit rising);
    ramp_lut_t lut;
    for (int i = 0; i < 16; i++) begin
      if (i < STEPS_PER_SECTOR) begin
        lut[i] = rising ? 8'((i * CHAN_FULL) / STEPS_PER_SECTOR)
                        : 8'(((STEPS_PER_SECTOR - i) * CHAN_FULL) / STEPS_PER_SECTOR);
      end else begin
        lut[i] = 8'd0;
      end
    end
    return lut;
  endfunction

  localparam hue_lut_t    HUE_LUT    = build_hue_lut();
  localparam idx_lut_t    IDX_LUT    = build_idx_lut();
  localparam bright_lut_t BRIGHT_LUT = build_bright_lut();
  localparam ramp_lut_t   RISE_LUT   = build_ramp_lut(1'b1);
  localparam ramp_lut_t   FALL_LUT   = build_ramp_lut(1'b0);

endpackage

`default_nettype wire

// File: rtl/core/mntl_front.sv
// front end: classifies a midi message and looks up index, hue and brightness
`timescale 1ns / 1ps
`default_nettype none

module mntl_front
  import mntl_pkg::*;
(
  input  wire logic [7:0] status_byte,
  input  wire logic [6:0] note_number,
  input  wire logic [6:0] note_velocity,
  input  wire logic [6:0] lowest_note,
  output logic            is_note,
  output note_item_t      item
);

  logic       note_on;
  logic       note_off;
  logic [7:0] hue_idx;
  logic [6:0] hue_code;
  logic [6:0] vel_eff;

  assign note_on  = (status_byte == STATUS_NOTE_ON);
  assign note_off = (status_byte == STATUS_NOTE_OFF);
  assign is_note  = note_on || note_off;

  // note off forces zero brightness
  assign vel_eff  = note_on ? note_velocity : 7'd0;

  assign hue_idx  = {1'b0, note_number} + 8'(HUE_OFFSET) - {1'b0, lowest_note};
  assign hue_code = HUE_LUT[hue_idx];

  always_comb begin
    item.led_index = IDX_LUT[note_number];
    item.sector    = hue_code[6:4];
    item.step      = hue_code[3:0];
    item.bright    = BRIGHT_LUT[vel_eff];
  end

endmodule

`default_nettype wire

// File: rtl/core/mntl_queue.sv
// small fifo decoupling the front end from the color back end
`timescale 1ns / 1ps
`default_nettype none

module mntl_queue
  import mntl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  note_item_t push_item,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output note_item_t pop_item
);

  note_item_t       store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = store_r[rd_ptr_r];

  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_fill_to_full: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop && (count_r == CNT_W'(QUEUE_DEPTH - 1)) |=> !push_ready)
    else $error("queue not full after last free slot was taken");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) || (count_r == CNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

// File: rtl/core/mntl_back.sv
// back end: hue wheel channel select, brightness multiply and divide by 255
`timescale 1ns / 1ps
`default_nettype none

module mntl_back
  import mntl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  item_valid,
  output logic       item_ready,
  input  note_item_t item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [6:0] out_led_index,
  output logic [23:0] out_led_color
);

  // stage 1: products
  logic        s1_valid_r;
  logic [6:0]  s1_index_r;
  logic [15:0] s1_red_r, s1_green_r, s1_blue_r;
  // stage 2: output register
  logic        out_valid_r;
  logic [6:0]  out_index_r;
  logic [23:0] out_color_r;

  logic        s1_ready, s2_ready, s1_load;
  logic [7:0]  rise, fall;
  logic [7:0]  red, green, blue;

  assign s2_ready   = !out_valid_r || out_ready;
  assign s1_ready   = !s1_valid_r || s2_ready;
  assign item_ready = s1_ready;
  assign s1_load    = item_valid && s1_ready;

  assign rise = RISE_LUT[item.step];
  assign fall = FALL_LUT[item.step];

  always_comb begin
    unique case (item.sector)
      SECTOR_RED_YELLOW:   begin red = 8'd255; green = rise;   blue = 8'd0;   end
      SECTOR_YELLOW_GREEN: begin red = fall;   green = 8'd255; blue = 8'd0;   end
      SECTOR_GREEN_CYAN:   begin red = 8'd0;   green = 8'd255; blue = rise;   end
      SECTOR_CYAN_BLUE:    begin red = 8'd0;   green = fall;   blue = 8'd255; end
      SECTOR_BLUE_MAGENTA: begin red = rise;   green = 8'd0;   blue = 8'd255; end
      default:             begin red = 8'd255; green = 8'd0;   blue = fall;   end
    endcase
  end

  // floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] sum;
    sum = x + {8'd0, x[15:8]} + 16'd1;
    return sum[15:8];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= item_valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_index_r <= item.led_index;
      s1_red_r   <= {8'd0, red} * {8'd0, item.bright};
      s1_green_r <= {8'd0, green} * {8'd0, item.bright};
      s1_blue_r  <= {8'd0, blue} * {8'd0, item.bright};
    end
    if (s2_ready && s1_valid_r) begin
      out_index_r <= s1_index_r;
      out_color_r <= {div255(s1_red_r), div255(s1_green_r), div255(s1_blue_r)};
    end
  end

  assign out_valid     = out_valid_r;
  assign out_led_index = out_index_r;
  assign out_led_color = out_color_r;

`ifndef NO_ASSERTIONS
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |=> s1_valid_r && $stable(s1_red_r))
    else $error("stage 1 lost a held item");

  a_s1_feeds_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_ready |=> out_valid_r)
    else $error("stage 1 item did not reach output");

  a_no_take_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !item_ready)
    else $error("back end took an item while stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/core/midi_note_to_led_color.sv
// top level: midi note message to led index and packed rgb color
//
//   channel | signals                                      | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid/in_ready, status, note, velocity    | to block
//   out     | out_valid/out_ready, led_index, led_color    | from block
//   cfg     | cfg_we, cfg_wdata (lowest_note)              | to block
//
// one message accepted per cycle while the four entry queue has room
// out_valid rises once the input transfer has passed the queue slot, then the product stage,
//   then the output register
// messages other than note on / note off are taken and dropped, giving no result
// synchronous active low reset empties the queue and pipeline, lowest_note back to 36
// a stalled output holds the pipeline; the queue absorbs up to four more note events
`timescale 1ns / 1ps
`default_nettype none

module midi_note_to_led_color
  import mntl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_status_byte,
  input  wire logic [6:0]  in_note_number,
  input  wire logic [6:0]  in_note_velocity,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_led_index,
  output logic [23:0]      out_led_color,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata
);

  // note that maps to hue zero
  logic [6:0] lowest_note_r;

  logic       is_note;
  note_item_t front_item;
  logic       q_push_ready;
  logic       q_pop_valid;
  logic       q_pop_ready;
  note_item_t q_pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_note_r <= LOWEST_NOTE_RESET;
    end else if (cfg_we) begin
      lowest_note_r <= cfg_wdata;
    end
  end

  // classify and look up per-note values
  mntl_front u_front (
    .status_byte   (in_status_byte),
    .note_number   (in_note_number),
    .note_velocity (in_note_velocity),
    .lowest_note   (lowest_note_r),
    .is_note       (is_note),
    .item          (front_item)
  );

  // input is taken whenever the queue has room, note events are pushed
  assign in_ready = q_push_ready;

  mntl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid && is_note),
    .push_ready (q_push_ready),
    .push_item  (front_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  // color generation and output register
  mntl_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (q_pop_valid),
    .item_ready    (q_pop_ready),
    .item          (q_pop_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_led_index (out_led_index),
    .out_led_color (out_led_color)
  );

endmodule

`default_nettype wire
